>>> rtl/core/lfuc_pkg.sv
// Shared constants, codes and control structs of the LFU key/value store.
`default_nettype none

package lfuc_pkg;

    // Default sizes of the store.
    localparam int DEF_ENTRIES    = 16;
    localparam int DEF_KEY_BITS   = 16;
    localparam int DEF_COUNT_BITS = 16;

    // Fixed widths of the port fields.
    localparam int KEY_W   = 16;
    localparam int VALUE_W = 32;
    localparam int CAP_W   = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes.
    localparam logic OP_GET = 1'b0;
    localparam logic OP_PUT = 1'b1;

    // Request context handed to the entry unit.
    typedef struct packed {
        logic touch;        // rank update is a hit touch, otherwise an insert
        logic evict;        // the insert removed a victim
        logic found;        // a matching entry has already been seen
        logic have_victim;  // a victim candidate has already been seen
        logic free_found;   // a free entry has already been seen
    } t_unit_ctl;

    // Per-entry decisions returned by the entry unit.
    typedef struct packed {
        logic match;        // first valid entry holding the requested key
        logic better;       // better victim than the current candidate
        logic take_free;    // first invalid entry
    } t_unit_flags;

endpackage

`default_nettype wire

>>> rtl/core/lfu_cache_with_lru_tiebreak_core.sv
// Top level of the LFU key/value store with least-recently-used tie break.
//
//  Channel  Direction  Handshake               Payload
//  in       input      i_in_valid / o_in_stall i_op, i_key, i_value
//  out      output     o_out_valid / i_out_stall o_hit, o_read_value, o_evicted,
//                                               o_evicted_key
//  cfg      input      i_cfg_we                i_cfg_wdata (capacity)
//
// A request scans every entry through one shared entry unit, one entry a cycle
// out of the entry memories. A hit or an insert then sweeps the rank memory
// once more; a request that neither hits nor inserts skips the sweep.
// Reset is synchronous and clears the entry valid bits and the fill count.
// A finished result waits in the output register while the next request is
// taken; only the end of that request waits for the output to be free.
`default_nettype none

module lfu_cache_with_lru_tiebreak_core #(
    parameter int ENTRIES    = lfuc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfuc_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfuc_pkg::DEF_COUNT_BITS
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_cfg_we,
    input  logic [lfuc_pkg::CAP_W-1:0]         i_cfg_wdata,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_op,
    input  logic [lfuc_pkg::KEY_W-1:0]         i_key,
    input  logic signed [lfuc_pkg::VALUE_W-1:0] i_value,
    output logic                               o_out_valid,
    input  logic                               i_out_stall,
    output logic                               o_hit,
    output logic signed [lfuc_pkg::VALUE_W-1:0] o_read_value,
    output logic                               o_evicted,
    output logic [lfuc_pkg::KEY_W-1:0]         o_evicted_key
);
    import lfuc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_DECIDE,
        S_SWEEP,
        S_DONE
    } t_state;

    t_state r_state;

    // Entry memories.
    logic [KEY_BITS-1:0]   r_mem_key   [ENTRIES];
    logic [VALUE_W-1:0]    r_mem_data  [ENTRIES];
    logic [COUNT_BITS-1:0] r_mem_count [ENTRIES];
    logic [IDX_W-1:0]      r_mem_rank  [ENTRIES];
    logic [ENTRIES-1:0]    r_valid;

    // Read stage.
    logic                  r_rd_go;
    logic [IDX_W-1:0]      r_rd_idx;
    logic                  r_rd_valid;
    logic [KEY_BITS-1:0]   r_rd_key;
    logic [VALUE_W-1:0]    r_rd_data;
    logic [COUNT_BITS-1:0] r_rd_count;
    logic [IDX_W-1:0]      r_rd_rank;

    // Request and scan results.
    logic [CNT_W-1:0]      r_idx;
    logic                  r_op;
    logic [KEY_BITS-1:0]   r_key;
    logic [VALUE_W-1:0]    r_value;
    logic                  r_found;
    logic [IDX_W-1:0]      r_hit_idx;
    logic [VALUE_W-1:0]    r_hit_data;
    logic [COUNT_BITS-1:0] r_hit_count;
    logic [IDX_W-1:0]      r_hit_rank;
    logic                  r_have_victim;
    logic [IDX_W-1:0]      r_vic_idx;
    logic [COUNT_BITS-1:0] r_vic_count;
    logic [IDX_W-1:0]      r_vic_rank;
    logic [KEY_BITS-1:0]   r_vic_key;
    logic                  r_free_found;
    logic [IDX_W-1:0]      r_free_idx;
    logic                  r_evict;
    logic [IDX_W-1:0]      r_slot;
    logic [CNT_W-1:0]      r_occ;
    logic [CAP_W-1:0]      r_cap;

    // Pending result and output register.
    logic                  r_res_hit;
    logic [VALUE_W-1:0]    r_res_data;
    logic                  r_res_evicted;
    logic [KEY_W-1:0]      r_res_evkey;
    logic                  r_out_valid;
    logic                  r_out_hit;
    logic [VALUE_W-1:0]    r_out_data;
    logic                  r_out_evicted;
    logic [KEY_W-1:0]      r_out_evkey;

    logic                  rd_en;
    logic [IDX_W-1:0]      rd_addr;
    logic                  rd_last;
    logic [KEY_BITS-1:0]   req_key;
    logic [31:0]           key_ext;
    logic [31:0]           vic_key_ext;
    t_unit_ctl             unit_ctl;
    t_unit_flags           unit_flags;
    logic [IDX_W-1:0]      unit_new_rank;
    logic [IDX_W-1:0]      ref_rank;

    logic [CMP_W-1:0]      cap_x;
    logic [CMP_W-1:0]      cap_eff;
    logic [CMP_W-1:0]      occ_x;
    logic                  d_insert;
    logic                  d_evict;
    logic                  d_sweep;
    logic [IDX_W-1:0]      d_slot;
    logic [COUNT_BITS-1:0] d_count;
    logic [ENTRIES-1:0]    n_valid;
    logic                  we_key;
    logic                  we_data;
    logic                  we_count;
    logic                  in_xfer;
    logic                  out_xfer;

    assign in_xfer  = i_in_valid && !o_in_stall;
    assign out_xfer = r_out_valid && !i_out_stall;

    assign key_ext = 32'(i_key);
    assign req_key = key_ext[KEY_BITS-1:0];

    assign rd_en   = ((r_state == S_SCAN) || (r_state == S_SWEEP)) &&
                     (r_idx != CNT_W'(ENTRIES));
    assign rd_addr = r_idx[IDX_W-1:0];
    assign rd_last = r_rd_go && (r_rd_idx == IDX_W'(ENTRIES - 1));

    // Capacity above the number of entries counts as the number of entries.
    assign cap_x   = CMP_W'(r_cap);
    assign cap_eff = (cap_x > CMP_W'(ENTRIES)) ? CMP_W'(ENTRIES) : cap_x;
    assign occ_x   = CMP_W'(r_occ);

    always_comb begin
        d_insert = !r_found && (r_op == OP_PUT) && (cap_eff != '0);
        d_evict  = d_insert && (occ_x >= cap_eff) && r_have_victim;
        d_sweep  = r_found || d_insert;
        if (r_found) begin
            d_slot = r_hit_idx;
        end else if (d_evict && !(r_free_found && (r_free_idx < r_vic_idx))) begin
            d_slot = r_vic_idx;
        end else begin
            d_slot = r_free_idx;
        end
        if (r_found) begin
            d_count = (r_hit_count == '1) ? r_hit_count : r_hit_count + 1'b1;
        end else begin
            d_count = COUNT_BITS'(1);
        end
    end

    // The victim is dropped first so that an insert into the same entry
    // leaves it valid.
    always_comb begin
        n_valid = r_valid;
        if (d_evict) begin
            n_valid[r_vic_idx] = 1'b0;
        end
        n_valid[d_slot] = 1'b1;
    end

    assign we_key   = (r_state == S_DECIDE) && d_insert;
    assign we_data  = (r_state == S_DECIDE) && d_sweep && (r_op == OP_PUT);
    assign we_count = (r_state == S_DECIDE) && d_sweep;

    assign vic_key_ext = 32'(r_vic_key);
    assign ref_rank    = r_found ? r_hit_rank : r_vic_rank;

    always_comb begin
        unit_ctl.touch       = r_found;
        unit_ctl.evict       = r_evict;
        unit_ctl.found       = r_found;
        unit_ctl.have_victim = r_have_victim;
        unit_ctl.free_found  = r_free_found;
    end

    lfuc_entry_unit #(
        .ENTRIES    (ENTRIES),
        .KEY_BITS   (KEY_BITS),
        .COUNT_BITS (COUNT_BITS),
        .IDX_W      (IDX_W)
    ) u_entry_unit (
        .i_ctl       (unit_ctl),
        .i_ent_valid (r_rd_valid),
        .i_ent_idx   (r_rd_idx),
        .i_ent_key   (r_rd_key),
        .i_ent_count (r_rd_count),
        .i_ent_rank  (r_rd_rank),
        .i_req_key   (r_key),
        .i_vic_count (r_vic_count),
        .i_vic_rank  (r_vic_rank),
        .i_ref_rank  (ref_rank),
        .i_slot      (r_slot),
        .o_flags     (unit_flags),
        .o_new_rank  (unit_new_rank)
    );

    // Memory read port, one entry a cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_go <= 1'b0;
        end else begin
            r_rd_go <= rd_en;
        end
        if (rd_en) begin
            r_rd_idx   <= rd_addr;
            r_rd_valid <= r_valid[rd_addr];
            r_rd_key   <= r_mem_key[rd_addr];
            r_rd_data  <= r_mem_data[rd_addr];
            r_rd_count <= r_mem_count[rd_addr];
            r_rd_rank  <= r_mem_rank[rd_addr];
        end
    end

    // Memory write ports.
    always_ff @(posedge i_clk) begin
        if (we_key) begin
            r_mem_key[d_slot] <= r_key;
        end
        if (we_data) begin
            r_mem_data[d_slot] <= r_value;
        end
        if (we_count) begin
            r_mem_count[d_slot] <= d_count;
        end
        if ((r_state == S_SWEEP) && r_rd_go && r_rd_valid) begin
            r_mem_rank[r_rd_idx] <= unit_new_rank;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_valid     <= '0;
            r_occ       <= '0;
            r_cap       <= CAP_RESET;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cap <= i_cfg_wdata;
            end
            // In S_DONE the output register is reloaded instead.
            if (out_xfer && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end
            if (rd_en) begin
                r_idx <= r_idx + 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer) begin
                        r_op          <= i_op;
                        r_key         <= req_key;
                        r_value       <= i_value;
                        r_found       <= 1'b0;
                        r_have_victim <= 1'b0;
                        r_free_found  <= 1'b0;
                        r_evict       <= 1'b0;
                        r_idx         <= '0;
                        r_state       <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_rd_go) begin
                        if (unit_flags.match) begin
                            r_found     <= 1'b1;
                            r_hit_idx   <= r_rd_idx;
                            r_hit_data  <= r_rd_data;
                            r_hit_count <= r_rd_count;
                            r_hit_rank  <= r_rd_rank;
                        end
                        if (unit_flags.better) begin
                            r_have_victim <= 1'b1;
                            r_vic_idx     <= r_rd_idx;
                            r_vic_count   <= r_rd_count;
                            r_vic_rank    <= r_rd_rank;
                            r_vic_key     <= r_rd_key;
                        end
                        if (unit_flags.take_free) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_rd_idx;
                        end
                    end
                    if (rd_last) begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_evict       <= d_evict;
                    r_slot        <= d_slot;
                    r_idx         <= '0;
                    r_res_hit     <= r_found;
                    r_res_data    <= r_found ? r_hit_data : '0;
                    r_res_evicted <= d_evict;
                    r_res_evkey   <= d_evict ? vic_key_ext[KEY_W-1:0] : '0;
                    if (d_insert) begin
                        if (!d_evict) begin
                            r_occ <= r_occ + 1'b1;
                        end
                        r_valid <= n_valid;
                    end
                    r_state <= d_sweep ? S_SWEEP : S_DONE;
                end
                S_SWEEP: begin
                    if (rd_last) begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_out_valid || !i_out_stall) begin
                        r_out_valid   <= 1'b1;
                        r_out_hit     <= r_res_hit;
                        r_out_data    <= r_res_data;
                        r_out_evicted <= r_res_evicted;
                        r_out_evkey   <= r_res_evkey;
                        r_state       <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall    = (r_state != S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_hit         = r_out_hit;
    assign o_read_value  = r_out_data;
    assign o_evicted     = r_out_evicted;
    assign o_evicted_key = r_out_evkey;

endmodule

`default_nettype wire

>>> rtl/core/lfuc_entry_unit.sv
// Shared per-entry unit: key match, victim compare, free search and rank update.
`default_nettype none

module lfuc_entry_unit #(
    parameter int ENTRIES    = lfuc_pkg::DEF_ENTRIES,
    parameter int KEY_BITS   = lfuc_pkg::DEF_KEY_BITS,
    parameter int COUNT_BITS = lfuc_pkg::DEF_COUNT_BITS,
    parameter int IDX_W      = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  lfuc_pkg::t_unit_ctl   i_ctl,
    input  logic                  i_ent_valid,
    input  logic [IDX_W-1:0]      i_ent_idx,
    input  logic [KEY_BITS-1:0]   i_ent_key,
    input  logic [COUNT_BITS-1:0] i_ent_count,
    input  logic [IDX_W-1:0]      i_ent_rank,
    input  logic [KEY_BITS-1:0]   i_req_key,
    input  logic [COUNT_BITS-1:0] i_vic_count,
    input  logic [IDX_W-1:0]      i_vic_rank,
    input  logic [IDX_W-1:0]      i_ref_rank,
    input  logic [IDX_W-1:0]      i_slot,
    output lfuc_pkg::t_unit_flags o_flags,
    output logic [IDX_W-1:0]      o_new_rank
);
    import lfuc_pkg::*;

    logic cnt_lt;
    logic cnt_eq;
    logic [IDX_W-1:0] rank_dec;

    assign cnt_lt = i_ent_count < i_vic_count;
    assign cnt_eq = i_ent_count == i_vic_count;

    always_comb begin
        o_flags.match     = i_ent_valid && !i_ctl.found && (i_ent_key == i_req_key);
        o_flags.better    = i_ent_valid && (!i_ctl.have_victim || cnt_lt ||
                                            (cnt_eq && (i_ent_rank > i_vic_rank)));
        o_flags.take_free = !i_ent_valid && !i_ctl.free_found;
    end

    // Ranks above the victim close the gap it leaves before every entry ages by one.
    assign rank_dec = (i_ctl.evict && (i_ent_rank > i_ref_rank)) ?
                      i_ent_rank - 1'b1 : i_ent_rank;

    always_comb begin
        if (i_ent_idx == i_slot) begin
            o_new_rank = '0;
        end else if (i_ctl.touch) begin
            o_new_rank = (i_ent_rank < i_ref_rank) ? i_ent_rank + 1'b1 : i_ent_rank;
        end else begin
            o_new_rank = rank_dec + 1'b1;
        end
    end

endmodule

`default_nettype wire

>>> rtl/core/lfuc_checker.sv
// Port-level checks of the LFU key/value store and their binding to the top level.
`default_nettype none

module lfuc_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               i_in_valid,
    input logic                               o_in_stall,
    input logic                               o_out_valid,
    input logic                               i_out_stall,
    input logic                               o_hit,
    input logic signed [lfuc_pkg::VALUE_W-1:0] o_read_value,
    input logic                               o_evicted,
    input logic [lfuc_pkg::KEY_W-1:0]         o_evicted_key
);
    import lfuc_pkg::*;

    // A result that waits for its transfer keeps its payload.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_hit) &&
        $stable(o_read_value) && $stable(o_evicted) && $stable(o_evicted_key))
        else $error("result changed while stalled");

    // A request that is taken holds off the next one while it is worked on.
    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after a transfer");

    // A hit never evicts.
    a_hit_no_evict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_hit && o_evicted))
        else $error("hit and eviction in one result");

    // Fields without meaning read as zero.
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_hit |-> o_read_value == '0)
        else $error("miss returned a non-zero value");

    a_no_evict_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_evicted |-> o_evicted_key == '0)
        else $error("evicted key set without an eviction");

endmodule

bind lfu_cache_with_lru_tiebreak_core lfuc_checker u_lfuc_checker (.*);

`default_nettype wire
